// ===== rtl/barometer_temp_pressure_compensation_defines.svh =====
// Assertion macros for the compensation block.
`ifndef BAROMETER_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETER_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BTPC_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define BTPC_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error(msg);
`endif

// ===== rtl/btpc_pkg.sv =====
package btpc_pkg;
	typedef enum logic [3:0] {
		OP_MUL,
		OP_ADD,
		OP_SUB,
		OP_ASR,
		OP_SHL,
		OP_SDIV,
		OP_UDIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		logic [4:0] sh;
	} alu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic dz;
	} alu_sts_t;

	localparam logic [31:0] B6_OFS   = 32'd4000;
	localparam logic [31:0] B7_MUL   = 32'd50000;
	localparam logic [31:0] P_K1     = 32'd3038;
	localparam logic [31:0] P_K2     = 32'hFFFF_E343;
	localparam logic [31:0] P_K3     = 32'd3791;
	localparam logic [31:0] B4_OFS   = 32'd32768;

	localparam logic [2:0] REG_AC12 = 3'd0;
	localparam logic [2:0] REG_AC34 = 3'd1;
	localparam logic [2:0] REG_AC56 = 3'd2;
	localparam logic [2:0] REG_B12  = 3'd3;
	localparam logic [2:0] REG_MCMD = 3'd4;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction
endpackage

// ===== rtl/btpc_alu.sv =====
module btpc_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  btpc_pkg::alu_ctl_t  ctl,
	input  logic [31:0]         a,
	input  logic [31:0]         b,
	output logic [31:0]         y,
	output btpc_pkg::alu_sts_t  sts
);
	import btpc_pkg::*;

	logic [31:0] num_q, den_q, quo_q, rem_q;
	logic [5:0]  cnt_q;
	logic        neg_q, div_q;
	logic [32:0] trial;
	logic [31:0] prod;

	// Only the low word of the product is ever needed.
	assign prod  = a * b;
	assign trial = {rem_q, num_q[31]} - {1'b0, den_q};

	// Restoring division, one quotient bit per cycle on magnitudes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q    <= 1'b0;
			sts      <= '0;
			cnt_q    <= '0;
		end else begin
			sts.done <= 1'b0;
			if (ctl.start) begin
				sts.dz <= 1'b0;
				unique case (ctl.op) inside
					OP_MUL: begin y <= prod; sts.done <= 1'b1; end
					OP_ADD: begin y <= a + b; sts.done <= 1'b1; end
					OP_SUB: begin y <= a - b; sts.done <= 1'b1; end
					OP_ASR: begin y <= $signed(a) >>> ctl.sh; sts.done <= 1'b1; end
					OP_SHL: begin y <= a << ctl.sh; sts.done <= 1'b1; end
					OP_SDIV, OP_UDIV: begin
						if (b == 32'd0) begin
							y <= 32'd0;
							sts.dz <= 1'b1;
							sts.done <= 1'b1;
						end else begin
							if (ctl.op == OP_SDIV) begin
								num_q <= a[31] ? -a : a;
								den_q <= b[31] ? -b : b;
								neg_q <= a[31] ^ b[31];
							end else begin
								num_q <= a;
								den_q <= b;
								neg_q <= 1'b0;
							end
							rem_q <= '0;
							quo_q <= '0;
							cnt_q <= 6'd32;
							div_q <= 1'b1;
							sts.busy <= 1'b1;
						end
					end
					default: begin y <= '0; sts.done <= 1'b1; end
				endcase
			end else if (div_q) begin
				if (cnt_q == 6'd0) begin
					y <= neg_q ? -quo_q : quo_q;
					div_q <= 1'b0;
					sts.busy <= 1'b0;
					sts.done <= 1'b1;
				end else begin
					num_q <= {num_q[30:0], 1'b0};
					if (!trial[32]) begin
						rem_q <= trial[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= {rem_q[30:0], num_q[31]};
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end
endmodule

// ===== rtl/barometer_temp_pressure_compensation.sv =====
// Barometer compensation: raw temperature or pressure readings in, true values out.
// Input transfer on s_axis: tdata bits 15..0 raw_reading, tuser req_type.
// Output transfer on m_axis: tdata bits 31..0 result_value,
// tuser bit 0 result_kind, bit 1 div_error.
// Calibration words are written on cfg_we/cfg_addr/cfg_wdata; the user must do so
// only while idle, the block itself does not enforce it. One item runs through a
// short sequencer that drives a single ALU (32x32 multiply, add, subtract, shift,
// and a radix-2 divider). Each step passes S_ISSUE and S_WAIT; the divide step
// works one quotient bit per cycle.
// s_axis_tready is low while an item is in work or its result is unsent.
// A stalled receiver holds the result in the output register; nothing is lost.
// Reset clears calibration, the stored B5 and all control state.
module barometer_temp_pressure_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // raw_reading
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // result_value
	output logic [1:0]  m_axis_tuser,  // result_kind, div_error
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);
	import btpc_pkg::*;
	`include "barometer_temp_pressure_compensation_defines.svh"

	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_t;

	state_t      state_q;
	logic [5:0]  pc_q;
	logic [31:0] r_q [8];
	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q, b5_q;
	logic        kind_q, err_q;
	logic [15:0] raw_q;

	alu_ctl_t    ctl;
	alu_sts_t    sts;
	logic [31:0] opa, opb, y;
	logic [2:0]  dst;
	logic        last, chk;

	btpc_alu u_alu (.clk(clk), .arst_n(arst_n), .ctl(ctl), .a(opa), .b(opb),
		.y(y), .sts(sts));

	// Microcode: each step reads operands, writes r_q[dst]; the last step gives the result.
	always_comb begin
		logic [31:0] rw;
		rw = {16'd0, raw_q};
		ctl.start = (state_q == S_ISSUE);
		ctl.op = OP_ADD;
		ctl.sh = 5'd0;
		opa = '0;
		opb = '0;
		dst = 3'd0;
		last = 1'b0;
		chk = 1'b0;
		if (!kind_q) begin
			case (pc_q)
				6'd0: begin ctl.op = OP_SUB; opa = rw; opb = {16'd0, ac56_q[31:16]}; end
				6'd1: begin ctl.op = OP_MUL; opa = r_q[0]; opb = {16'd0, ac56_q[15:0]}; end
				6'd2: begin ctl.op = OP_ASR; opa = r_q[0]; ctl.sh = 5'd15; dst = 3'd1; end
				6'd3: begin ctl.op = OP_ADD; opa = r_q[1]; opb = sx16(mcmd_q[31:16]); dst = 3'd2; end
				6'd4: begin
					ctl.op = OP_SDIV; opa = {sx16(mcmd_q[15:0]) << 11}; opb = r_q[2];
					dst = 3'd3; chk = 1'b1;
				end
				6'd5: begin ctl.op = OP_ADD; opa = r_q[1]; opb = r_q[3]; dst = 3'd4; end
				6'd6: begin ctl.op = OP_ADD; opa = r_q[4]; opb = 32'd8; end
				default: begin ctl.op = OP_ASR; opa = r_q[0]; ctl.sh = 5'd4; last = 1'b1; end
			endcase
		end else begin
			// r1 b6, r2 sq, r3 x3, r4 b3, r5 b4, r6 b7/p, r7 scratch
			case (pc_q)
				6'd0: begin ctl.op = OP_SUB; opa = b5_q; opb = B6_OFS; dst = 3'd1; end
				6'd1: begin ctl.op = OP_MUL; opa = r_q[1]; opb = r_q[1]; end
				6'd2: begin ctl.op = OP_ASR; opa = r_q[0]; ctl.sh = 5'd12; dst = 3'd2; end
				6'd3: begin ctl.op = OP_MUL; opa = sx16(b12_q[31:16]); opb = r_q[2]; end
				6'd4: begin ctl.op = OP_ASR; opa = r_q[0]; ctl.sh = 5'd11; dst = 3'd3; end
				6'd5: begin ctl.op = OP_MUL; opa = sx16(ac12_q[31:16]); opb = r_q[1]; end
				6'd6: begin ctl.op = OP_ASR; opa = r_q[0]; ctl.sh = 5'd11; end
				6'd7: begin ctl.op = OP_ADD; opa = r_q[0]; opb = r_q[3]; dst = 3'd3; end
				6'd8: begin ctl.op = OP_SHL; opa = sx16(ac12_q[15:0]); ctl.sh = 5'd2; end
				6'd9: begin ctl.op = OP_ADD; opa = r_q[0]; opb = r_q[3]; end
				6'd10: begin ctl.op = OP_ADD; opa = r_q[0]; opb = 32'd2; end
				6'd11: begin ctl.op = OP_ASR; opa = r_q[0]; ctl.sh = 5'd2; dst = 3'd4; end
				6'd12: begin ctl.op = OP_MUL; opa = sx16(ac34_q[15:0]); opb = r_q[1]; end
				6'd13: begin ctl.op = OP_ASR; opa = r_q[0]; ctl.sh = 5'd13; dst = 3'd7; end
				6'd14: begin ctl.op = OP_MUL; opa = sx16(b12_q[15:0]); opb = r_q[2]; end
				6'd15: begin ctl.op = OP_ASR; opa = r_q[0]; ctl.sh = 5'd16; end
				6'd16: begin ctl.op = OP_ADD; opa = r_q[0]; opb = r_q[7]; end
				6'd17: begin ctl.op = OP_ADD; opa = r_q[0]; opb = 32'd2; end
				6'd18: begin ctl.op = OP_ASR; opa = r_q[0]; ctl.sh = 5'd2; end
				6'd19: begin ctl.op = OP_ADD; opa = r_q[0]; opb = B4_OFS; end
				6'd20: begin ctl.op = OP_MUL; opa = {16'd0, ac34_q[31:16]}; opb = r_q[0]; end
				6'd21: begin
					ctl.op = OP_ASR; opa = {1'b0, r_q[0][31:1]}; ctl.sh = 5'd14;
					dst = 3'd5;
				end
				6'd22: begin ctl.op = OP_SUB; opa = rw; opb = r_q[4]; end
				6'd23: begin ctl.op = OP_MUL; opa = r_q[0]; opb = B7_MUL; dst = 3'd6; end
				6'd24: begin
					ctl.op = r_q[6][31] ? OP_UDIV : OP_SHL; opa = r_q[6]; opb = r_q[5];
					ctl.sh = 5'd1; chk = r_q[6][31];
				end
				6'd25: begin
					ctl.op = r_q[6][31] ? OP_SHL : OP_UDIV; opa = r_q[0]; opb = r_q[5];
					ctl.sh = 5'd1; dst = 3'd6; chk = !r_q[6][31];
				end
				6'd26: begin ctl.op = OP_ASR; opa = r_q[6]; ctl.sh = 5'd8; dst = 3'd7; end
				6'd27: begin ctl.op = OP_MUL; opa = r_q[7]; opb = r_q[7]; end
				6'd28: begin ctl.op = OP_MUL; opa = r_q[0]; opb = P_K1; end
				6'd29: begin ctl.op = OP_ASR; opa = r_q[0]; ctl.sh = 5'd16; dst = 3'd7; end
				6'd30: begin ctl.op = OP_MUL; opa = P_K2; opb = r_q[6]; end
				6'd31: begin ctl.op = OP_ASR; opa = r_q[0]; ctl.sh = 5'd16; end
				6'd32: begin ctl.op = OP_ADD; opa = r_q[0]; opb = r_q[7]; end
				6'd33: begin ctl.op = OP_ADD; opa = r_q[0]; opb = P_K3; end
				6'd34: begin ctl.op = OP_ASR; opa = r_q[0]; ctl.sh = 5'd4; end
				default: begin ctl.op = OP_ADD; opa = r_q[6]; opb = r_q[0]; last = 1'b1; end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tuser  = {err_q, kind_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			ac12_q <= '0; ac34_q <= '0; ac56_q <= '0; b12_q <= '0; mcmd_q <= '0;
			b5_q <= '0;
			kind_q <= 1'b0;
			err_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_AC12: ac12_q <= cfg_wdata;
					REG_AC34: ac34_q <= cfg_wdata;
					REG_AC56: ac56_q <= cfg_wdata;
					REG_B12:  b12_q  <= cfg_wdata;
					REG_MCMD: mcmd_q <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (s_axis_tvalid) begin
					kind_q <= s_axis_tuser;
					raw_q <= s_axis_tdata;
					err_q <= 1'b0;
					pc_q <= '0;
					state_q <= S_ISSUE;
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: if (sts.done) begin
					if (chk && sts.dz) begin
						err_q <= 1'b1;
						m_axis_tdata <= '0;
						state_q <= S_OUT;
					end else if (last) begin
						m_axis_tdata <= y;
						if (!kind_q) b5_q <= r_q[4];
						state_q <= S_OUT;
					end else begin
						r_q[dst] <= y;
						pc_q <= pc_q + 6'd1;
						state_q <= S_ISSUE;
					end
				end
				S_OUT: if (m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BTPC_ASSERT_IMPL(a_ready_idle, clk, arst_n, s_axis_tready, !m_axis_tvalid && !sts.busy,
		"input ready while busy")
	`BTPC_ASSERT_NEXT(a_hold_out, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")
	`BTPC_ASSERT_IMPL(a_err_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser[1],
		m_axis_tdata == 32'd0, "error result not zero")
endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import btpc_pkg::*;

	typedef struct {
		logic        kind;
		logic [31:0] value;
		logic        dz;
	} comp_result_t;

	class comp_scoreboard;
		logic [31:0] ac12, ac34, ac56, b12, mcmd;
		logic [31:0] b5;
		comp_result_t pending[$];
		int errors;

		function void reset_state();
			ac12 = 0; ac34 = 0; ac56 = 0; b12 = 0; mcmd = 0; b5 = 0;
			errors = 0;
		endfunction

		function void write_cal(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_AC12: ac12 = v;
				REG_AC34: ac34 = v;
				REG_AC56: ac56 = v;
				REG_B12: b12 = v;
				REG_MCMD: mcmd = v;
				default: ;
			endcase
		endfunction

		function void note_reading(logic kind, logic [15:0] raw);
			comp_result_t r;
			logic signed [31:0] x1, x2, x3, den, b6, sq, b3, sac1, sac2, sac3, sb1, sb2;
			logic signed [31:0] smc, smd;
			logic [31:0] ac4, ac5, ac6, b4, b7, p, ph;
			logic signed [63:0] qn, qd;
			r.kind = kind; r.value = 0; r.dz = 0;
			if (kind == 1'b0) begin
				ac5 = {16'd0, ac56[15:0]};
				ac6 = {16'd0, ac56[31:16]};
				smc = {{16{mcmd[15]}}, mcmd[15:0]};
				smd = {{16{mcmd[31]}}, mcmd[31:16]};
				x1 = 32'(({16'd0, raw} - ac6) * ac5);
				x1 = x1 >>> 15;
				den = x1 + smd;
				if (den == 0) r.dz = 1;
				else begin
					qn = 64'(signed'(32'(smc << 11)));
					qd = 64'(den);
					x2 = 32'(qn / qd);
					b5 = x1 + x2;
					r.value = 32'(signed'(b5 + 32'd8) >>> 4);
				end
			end else begin
				sac1 = {{16{ac12[15]}}, ac12[15:0]};
				sac2 = {{16{ac12[31]}}, ac12[31:16]};
				sac3 = {{16{ac34[15]}}, ac34[15:0]};
				ac4 = {16'd0, ac34[31:16]};
				sb1 = {{16{b12[15]}}, b12[15:0]};
				sb2 = {{16{b12[31]}}, b12[31:16]};
				b6 = b5 - 32'd4000;
				sq = 32'(b6 * b6); sq = sq >>> 12;
				x1 = 32'(sb2 * sq); x1 = x1 >>> 11;
				x2 = 32'(sac2 * b6); x2 = x2 >>> 11;
				x3 = x1 + x2;
				b3 = 32'((sac1 << 2) + x3 + 32'sd2); b3 = b3 >>> 2;
				x1 = 32'(sac3 * b6); x1 = x1 >>> 13;
				x2 = 32'(sb1 * sq); x2 = x2 >>> 16;
				x3 = 32'(x1 + x2 + 32'sd2); x3 = x3 >>> 2;
				b4 = 32'(ac4 * 32'(x3 + 32'sd32768)) >> 15;
				b7 = 32'(32'({16'd0, raw} - b3) * 32'd50000);
				if (b4 == 0) r.dz = 1;
				else begin
					if (!b7[31]) p = (b7 << 1) / b4;
					else p = (b7 / b4) << 1;
					ph = 32'(signed'(p) >>> 8);
					x1 = 32'(ph * ph);
					x1 = 32'(x1 * 32'sd3038); x1 = x1 >>> 16;
					x2 = 32'(32'hFFFF_E343 * p); x2 = x2 >>> 16;
					x3 = 32'(x1 + x2 + 32'sd3791);
					r.value = p + 32'(x3 >>> 4);
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [31:0] value, logic [1:0] user);
			comp_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result value=%h user=%b", $time, value, user);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (user[0] !== e.kind || value !== e.value || user[1] !== e.dz) begin
				$display("%0t: mismatch expected kind=%b value=%h dz=%b actual kind=%b value=%h dz=%b",
					$time, e.kind, e.value, e.dz, user[0], value, user[1]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0, s_axis_tready;
	logic [15:0] s_axis_tdata = 0;
	logic s_axis_tuser = 0;
	logic m_axis_tvalid, m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_we = 0;
	logic [2:0] cfg_addr = 0;
	logic [31:0] cfg_wdata = 0;

	comp_scoreboard sb;
	int idle_cycles = 0;
	int stall_hold;
	bit long_hold;

	always #1 clk = ~clk;

	barometer_temp_pressure_compensation uut (.*);

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) sb.note_reading(s_axis_tuser, s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: random stall per transfer, with one long hold-off on request.
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_axis_tready <= 0;
				repeat (stall_hold) @(negedge clk);
				long_hold = 0;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (w > 0) begin
				m_axis_tready <= 0;
				repeat (w) @(negedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	task automatic write_cal(logic [2:0] idx, logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
		sb.write_cal(idx, v);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_reading(logic kind, logic [15:0] raw, bit burst);
		int w;
		w = burst ? 0 : $urandom_range(0, 8);
		repeat (w) begin
			@(negedge clk);
			s_axis_tvalid <= 0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1; s_axis_tuser <= kind; s_axis_tdata <= raw;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		@(negedge clk);
		s_axis_tvalid <= 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic load_cal(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] d, logic [31:0] e);
		write_cal(REG_AC12, a); write_cal(REG_AC34, b); write_cal(REG_AC56, c);
		write_cal(REG_B12, d); write_cal(REG_MCMD, e);
	endtask

	task automatic random_cal();
		load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Calibration close to a real part, with a little jitter.
	task automatic typical_cal();
		load_cal({16'(-72 + $urandom_range(0, 20)), 16'(408 + $urandom_range(0, 40))},
			{16'(32741 + $urandom_range(0, 300)), 16'(-14383 + $urandom_range(0, 200))},
			{16'(23153 + $urandom_range(0, 3000)), 16'(32757 + $urandom_range(0, 3000))},
			{16'(4 + $urandom_range(0, 8)), 16'(6190 + $urandom_range(0, 100))},
			{16'(2868 - $urandom_range(0, 200)), 16'(-8711 + $urandom_range(0, 500))});
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		long_hold = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Pressure before any temperature, all calibration zero: divisor is zero.
		send_reading(1, 16'd0, 0);
		send_reading(0, 16'd0, 0);
		send_reading(1, 16'hFFFF, 0);
		drain();
		typical_cal();
		send_reading(1, 16'd23843, 0);
		send_reading(0, 16'd27898, 0);
		send_reading(1, 16'd23843, 0);
		send_reading(0, 16'hFFFF, 0);
		send_reading(1, 16'hFFFF, 0);
		send_reading(0, 16'd0, 0);
		send_reading(1, 16'd0, 0);
		drain();
		// Temperature divisor zero: AC5 zero and MD zero; B5 must keep its value.
		load_cal(32'h0198_FFBA, 32'hC7E1_8000, 32'h8000_0000, 32'h8000_7FFF, 32'h0000_8000);
		send_reading(0, 16'd1234, 0);
		send_reading(1, 16'd30000, 0);
		drain();
		// Divide by minus one: AC5 zero and MD -1 give a divisor of -1 for MC << 11.
		load_cal(32'h7FFF_8000, 32'hFFFF_7FFF, 32'h0000_0000, 32'h7FFF_8000, 32'hFFFF_0000);
		send_reading(0, 16'd5, 0);
		send_reading(1, 16'd5, 0);
		drain();
		load_cal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_reading(0, 16'h8000, 0);
		send_reading(1, 16'h8000, 0);
		drain();

		for (int ph = 0; ph < 18; ph++) begin
			if (ph % 3 == 2) random_cal(); else typical_cal();
			if (ph == 4) begin
				stall_hold = 400;
				long_hold = 1;
				for (int i = 0; i < 10; i++)
					send_reading(1'($urandom_range(0, 1)), 16'($urandom), 1);
			end
			for (int i = 0; i < 56; i++) begin
				bit burst;
				burst = (ph % 4 == 1);
				if ($urandom_range(0, 9) < 8) begin
					send_reading(0, 16'(27000 + $urandom_range(0, 4000)), burst);
					send_reading(1, 16'(20000 + $urandom_range(0, 8000)), burst);
				end else
					send_reading(1'($urandom_range(0, 1)), 16'($urandom), burst);
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
